>>> src/cas_pkg.sv
// Package for the compacting array store: field widths, request and status codes,
// and default sizes of the store. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cas_pkg;

    localparam int ACTION_W  = 2;
    localparam int INDEX_W   = 8;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;

    localparam int DEPTH_DEF      = 256;
    localparam int WORD_WIDTH_DEF = 32;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_APPEND  = 2'd0;
    localparam action_t ACT_REMOVE  = 2'd1;
    localparam action_t ACT_REPLACE = 2'd2;
    localparam action_t ACT_READ    = 2'd3;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_RANGE = 2'd2;

endpackage

`default_nettype wire

>>> src/cas_ifs.sv
// Request and response channel interfaces of the compacting array store.
// Both depend on cas_pkg for the field widths and code types.
`timescale 1ns / 1ps
`default_nettype none

interface cas_req_if
    import cas_pkg::*;
();
    logic                       valid;
    logic                       ready;
    action_t                    action;
    logic        [INDEX_W-1:0]  index;
    logic signed [VALUE_W-1:0]  value;

    modport source (output valid, output action, output index, output value, input ready);
    modport sink   (input valid, input action, input index, input value, output ready);
endinterface

interface cas_rsp_if
    import cas_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [VALUE_W-1:0]  read_value;
    logic        [COUNT_W-1:0]  count;
    status_t                    status;

    modport source (output valid, output read_value, output count, output status, input ready);
    modport sink   (input valid, input read_value, input count, input status, output ready);
endinterface

`default_nettype wire

>>> src/compacting_array_store_unit.sv
// Compacting array store: a two-port word memory with a fill count, driven by a small
// sequencer. Depends on cas_pkg and on the channel interfaces in cas_ifs.sv.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps up to DEPTH words packed at positions 0 to count-1. Each request beat
// appends, removes, replaces or reads one entry and yields exactly one response beat
// that carries the read word (reads only, otherwise zero), the count after the request
// and a status: done, store full with the append dropped, or index out of range with
// the request ignored. Requests are handled one at a time. Append, replace and any
// rejected request are finished in the cycle they are taken; a read also passes
// through the S_READ state, because the memory's read data is registered. A remove
// walks every later entry down by one position through the memory's single read
// port and single write port, one entry per cycle with the read of the next entry
// overlapping the write of the previous one, and holds the block until the last
// entry has moved. The response sits in an output register, and a new request is
// taken only when that register is empty or is being emptied in the same cycle, so
// a response that waits to be collected holds off the next request. The store needs
// no clearing pass: entries at or beyond the count are never read back. The count
// field carries the low nine bits of the fill count.
module compacting_array_store_unit
    import cas_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int WORD_WIDTH = WORD_WIDTH_DEF
)(
    input  wire           clk,
    input  wire           rst_n,
    cas_req_if.sink       req,
    cas_rsp_if.source     rsp
);

    // Address width, fill count width, and a width wide enough to compare the request
    // index with the count whichever of the two is wider.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > INDEX_W) ? CW : INDEX_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;

    // Sequencer state.
    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       fill_count_reg, fill_count_next;
    logic [CW-1:0]       sp_reg, sp_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;

    // Response register.
    logic                out_valid_reg;
    logic [VALUE_W-1:0]  out_value_reg;
    logic [COUNT_W-1:0]  out_count_reg;
    status_t             out_status_reg;

    logic                out_load;
    logic [VALUE_W-1:0]  load_value;
    logic [CW-1:0]       load_count;
    status_t             load_status;

    // Word memory with one write port and one registered read port.
    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]         rd_addr;
    logic                  mem_we;
    logic [AW-1:0]         mem_wa;
    logic [WORD_WIDTH-1:0] mem_wd;

    logic                accept;
    logic [XW-1:0]       idx_x;
    logic                in_range;
    logic                store_full;
    logic [CW-1:0]       sp_inc;
    logic                more_to_shift;

    // A new request is taken only when the sequencer is free and the response register
    // is empty or being emptied in this cycle.
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // Since the count never exceeds DEPTH, an index below the count is also a valid
    // memory address.
    assign idx_x         = XW'(req.index);
    assign in_range      = idx_x < XW'(fill_count_reg);
    assign store_full    = fill_count_reg == CW'(DEPTH);
    assign sp_inc        = sp_reg + CW'(1);
    assign more_to_shift = sp_inc < fill_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        sp_next         = sp_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;

        mem_we  = 1'b0;
        mem_wa  = AW'(fill_count_reg);
        mem_wd  = WORD_WIDTH'($unsigned(req.value));
        rd_addr = AW'(idx_x);

        out_load    = 1'b0;
        load_value  = '0;
        load_count  = fill_count_reg;
        load_status = ST_DONE;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == ACT_APPEND)
                    begin
                        out_load = 1'b1;
                        if (store_full)
                        begin
                            load_status = ST_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            fill_count_next = fill_count_reg + CW'(1);
                            load_count      = fill_count_reg + CW'(1);
                        end
                    end
                    else if (!in_range)
                    begin
                        out_load    = 1'b1;
                        load_status = ST_RANGE;
                    end
                    else
                    begin
                        case (req.action)
                            ACT_REMOVE:
                            begin
                                sp_next    = CW'(idx_x);
                                pend_next  = 1'b0;
                                state_next = S_SHIFT;
                            end
                            ACT_REPLACE:
                            begin
                                mem_we   = 1'b1;
                                mem_wa   = AW'(idx_x);
                                out_load = 1'b1;
                            end
                            ACT_READ:
                            begin
                                state_next = S_READ;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_READ:
            begin
                out_load   = 1'b1;
                load_value = VALUE_W'(rd_data_reg);
                state_next = S_IDLE;
            end
            S_SHIFT:
            begin
                // The word read in the previous cycle lands one place lower.
                if (pend_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = pend_addr_reg;
                    mem_wd = rd_data_reg;
                end
                if (more_to_shift)
                begin
                    rd_addr        = AW'(sp_inc);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(sp_reg);
                    sp_next        = sp_inc;
                end
                else
                begin
                    pend_next       = 1'b0;
                    fill_count_next = fill_count_reg - CW'(1);
                    out_load        = 1'b1;
                    load_count      = fill_count_reg - CW'(1);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_count_reg <= '0;
            sp_reg         <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            sp_reg         <= sp_next;
            pend_reg       <= pend_next;
            pend_addr_reg  <= pend_addr_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_value_reg  <= load_value;
            out_count_reg  <= COUNT_W'(load_count);
            out_status_reg <= load_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = $signed(out_value_reg);
    assign rsp.count      = out_count_reg;
    assign rsp.status     = out_status_reg;

    // The fill count never passes the depth of the store.
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CW'(DEPTH))
        else $error("fill count beyond store depth");

    // A dropped append is only ever reported against a full store.
    a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (load_status == ST_FULL) |-> store_full)
        else $error("full status reported for a store with room");

    // During a remove the walk pointer stays inside the occupied entries.
    a_shift_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (sp_reg < fill_count_reg))
        else $error("shift pointer outside occupied entries");

    // A rejected request leaves the count where it was.
    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && (load_status != ST_DONE) |=> $stable(fill_count_reg))
        else $error("rejected request changed the fill count");

endmodule

`default_nettype wire
